[design/psrr_pkg.sv]
package psrr_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int KIND_W   = 3;
    localparam int PID_W    = 4;
    localparam int STATUS_W = 3;
    localparam int STATE_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        K_CREATE    = 3'd0,
        K_START     = 3'd1,
        K_TERMINATE = 3'd2,
        K_FREE      = 3'd3,
        K_YIELD     = 3'd4,
        K_SCHEDULE  = 3'd5,
        K_READ      = 3'd6
    } t_kind;

    typedef enum logic [STATE_W-1:0] {
        SS_EMPTY      = 3'd0,
        SS_CREATED    = 3'd1,
        SS_READY      = 3'd2,
        SS_RUNNING    = 3'd3,
        SS_TERMINATED = 3'd4
    } t_slot_state;

    typedef enum logic [STATUS_W-1:0] {
        RS_OK        = 3'd0,
        RS_BAD_SLOT  = 3'd1,
        RS_BAD_STATE = 3'd2,
        RS_FULL      = 3'd3,
        RS_DISABLED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TCHK,
        S_YCHK,
        S_CURRPT,
        S_SCAN,
        S_POST,
        S_FIXCUR,
        S_SWOLD,
        S_SWNEW,
        S_DONE
    } t_ctrl_state;

    typedef enum logic [1:0] {
        RD_TARGET,
        RD_CURRENT,
        RD_SCAN
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_TARGET,
        WR_CURRENT,
        WR_PICK
    } t_wr_sel;

    typedef enum logic {
        BASE_CURRENT,
        BASE_LAST
    } t_scan_base;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic        load;
        t_rd_sel     rd_sel;
        logic        wr_en;
        t_wr_sel     wr_sel;
        t_slot_state wr_state;
        logic        scan_start;
        t_scan_base  scan_base;
        t_slot_state scan_want;
        logic        scan_run;
        logic        set_status;
        t_status     status;
        logic        set_sstate;
        logic        sstate_from_rd;
        t_slot_state sstate;
        logic        alloc;
        logic        do_switch;
        logic        out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              slot_valid;
        logic              slot_zero;
        logic              slot_is_cur;
        logic              enable;
        t_slot_state       rd_state;
        logic              scan_done;
        logic              found;
        logic              pick_is_cur;
        logic              out_free;
    } t_dp_stat;

endpackage

[design/psrr_ifs.sv]
interface psrr_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [psrr_pkg::KIND_W-1:0] kind;
    logic [psrr_pkg::PID_W-1:0]  slot_pid;

    modport source (output valid, output kind, output slot_pid, input ready);
    modport sink   (input valid, input kind, input slot_pid, output ready);
endinterface

interface psrr_res_if;
    logic                          valid;
    logic                          ready;
    logic [psrr_pkg::STATUS_W-1:0] status;
    logic [psrr_pkg::PID_W-1:0]    result_pid;
    logic [psrr_pkg::STATE_W-1:0]  slot_state_out;
    logic [psrr_pkg::PID_W-1:0]    running_pid;

    modport source (output valid, output status, output result_pid,
                    output slot_state_out, output running_pid, input ready);
    modport sink   (input valid, input status, input result_pid,
                    input slot_state_out, input running_pid, output ready);
endinterface

interface psrr_cfg_if;
    logic valid;
    logic ready;
    logic scheduler_enable;

    modport source (output valid, output scheduler_enable, input ready);
    modport sink   (input valid, input scheduler_enable, output ready);
endinterface

[design/process_slot_round_robin_scheduler.sv]
// Round-robin process slot scheduler. Each command word (create, start,
// terminate, free, yield, schedule, read state) yields exactly one result
// word holding a status, the slot allocated by create, the target or current
// slot's state and the running slot after the command. Slot states live in a
// single-port-read table with per-slot valid flags, so reset takes effect at
// once and no clearing pass is needed. Commands are handled one at a time.
// An undefined kind goes from decode straight to the result. Read, start,
// free, terminate without a reschedule, yield while the current slot is not
// running and a disabled yield or schedule need no scan. Create, and with
// the scheduler enabled schedule, yield of the running slot and terminate of
// the current slot, scan the table one slot per cycle through its registered
// read port, stopping early when a match is found. A new word is taken only
// after the result of the last one is loaded into the output register. The
// result sits in an output register, so a stalled consumer only holds the
// block in its final state. The scheduler_enable register is written through
// its own channel, which is always ready, and must only be written while no
// command is in flight.
module process_slot_round_robin_scheduler (
    input logic        i_clk,
    input logic        i_rst_n,
    psrr_cmd_if.sink   i_cmd,
    psrr_res_if.source o_res,
    psrr_cfg_if.sink   i_cfg
);
    import psrr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cmd_ready;

    // Configuration is a single flop: always take the word
    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = cmd_ready;

    psrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    psrr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_kind            (i_cmd.kind),
        .i_slot_pid        (i_cmd.slot_pid),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_enable      (i_cfg.scheduler_enable),
        .i_res_ready       (o_res.ready),
        .o_res_valid       (o_res.valid),
        .o_res_status      (o_res.status),
        .o_res_result_pid  (o_res.result_pid),
        .o_res_slot_state  (o_res.slot_state_out),
        .o_res_running_pid (o_res.running_pid)
    );

endmodule

[design/psrr_dp.sv]
module psrr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psrr_pkg::t_dp_cmd             i_cmd,
    output psrr_pkg::t_dp_stat            o_stat,
    input  logic [psrr_pkg::KIND_W-1:0]   i_kind,
    input  logic [psrr_pkg::PID_W-1:0]    i_slot_pid,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_enable,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output logic [psrr_pkg::STATUS_W-1:0] o_res_status,
    output logic [psrr_pkg::PID_W-1:0]    o_res_result_pid,
    output logic [psrr_pkg::STATE_W-1:0]  o_res_slot_state,
    output logic [psrr_pkg::PID_W-1:0]    o_res_running_pid
);
    import psrr_pkg::*;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
        return res;
    endfunction

    logic [KIND_W-1:0]  r_kind;
    logic [PID_W-1:0]   r_slot;
    logic               r_enable;
    logic [IDX_W-1:0]   r_current;
    logic [IDX_W-1:0]   r_last;
    logic [31:0]        r_switch_cnt;

    logic [STATE_W-1:0] r_slot_mem [SLOTS];
    logic [SLOTS-1:0]   r_vld;
    logic [STATE_W-1:0] r_rd_data;
    logic               r_rd_hit;
    logic [IDX_W-1:0]   r_rd_addr;

    logic [IDX_W-1:0]   r_scan_ptr;
    logic [CNT_W-1:0]   r_scan_cnt;
    logic               r_probe_vld;
    logic               r_probe_last;
    t_slot_state        r_want;
    logic [IDX_W-1:0]   r_pick;
    logic               r_found;

    t_status            r_res_status;
    logic [PID_W-1:0]   r_res_rpid;
    t_slot_state        r_res_sstate;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [PID_W-1:0]   r_out_rpid;
    t_slot_state        r_out_sstate;
    logic [PID_W-1:0]   r_out_running;

    logic [IDX_W-1:0]   n_rd_addr;
    logic [IDX_W-1:0]   n_wr_addr;
    logic [IDX_W-1:0]   n_scan_base;
    logic [IDX_W-1:0]   slot_idx;
    t_slot_state        rd_state;
    logic               scan_hit;
    logic               scan_done;

    assign slot_idx = IDX_W'(r_slot);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_TARGET:  n_rd_addr = slot_idx;
            RD_CURRENT: n_rd_addr = r_current;
            RD_SCAN:    n_rd_addr = r_scan_ptr;
            default:    n_rd_addr = r_current;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_TARGET:  n_wr_addr = slot_idx;
            WR_CURRENT: n_wr_addr = r_current;
            WR_PICK:    n_wr_addr = r_pick;
            default:    n_wr_addr = r_current;
        endcase
    end

    // An entry never written reads as its reset state
    assign rd_state = r_rd_hit ? t_slot_state'(r_rd_data)
                    : ((r_rd_addr == '0) ? SS_RUNNING : SS_EMPTY);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_slot_mem[n_wr_addr] <= i_cmd.wr_state;
        end
        r_rd_data <= r_slot_mem[n_rd_addr];
        r_rd_hit  <= r_vld[n_rd_addr];
        r_rd_addr <= n_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[n_wr_addr] <= 1'b1;
        end
    end

    // Scan: one probe issued per cycle, checked when its data returns
    assign n_scan_base = (i_cmd.scan_base == BASE_LAST) ? r_last : r_current;
    assign scan_hit  = r_probe_vld && (r_rd_addr != '0) && (rd_state == r_want);
    assign scan_done = scan_hit || (r_probe_vld && r_probe_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_vld <= 1'b0;
            r_scan_cnt  <= '0;
        end else if (i_cmd.scan_start) begin
            r_scan_ptr  <= wrap_inc(n_scan_base);
            r_scan_cnt  <= '0;
            r_probe_vld <= 1'b0;
            r_want      <= i_cmd.scan_want;
        end else if (i_cmd.scan_run) begin
            if (r_scan_cnt != CNT_W'(SLOTS)) begin
                r_scan_ptr   <= wrap_inc(r_scan_ptr);
                r_scan_cnt   <= r_scan_cnt + 1'b1;
                r_probe_vld  <= 1'b1;
                r_probe_last <= (r_scan_cnt == CNT_W'(SLOTS - 1));
            end else begin
                r_probe_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && scan_done) begin
            r_pick  <= scan_hit ? r_rd_addr : '0;
            r_found <= scan_hit;
        end
    end

    // Scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_current    <= '0;
            r_last       <= '0;
            r_switch_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_enable;
            end
            if (i_cmd.alloc) begin
                r_last <= r_pick;
            end
            if (i_cmd.do_switch) begin
                r_current    <= r_pick;
                r_switch_cnt <= r_switch_cnt + 32'd1;
            end
        end
    end

    // Command word and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind       <= i_kind;
            r_slot       <= i_slot_pid;
            r_res_status <= RS_OK;
            r_res_rpid   <= '0;
            r_res_sstate <= SS_EMPTY;
        end else begin
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status;
            end
            if (i_cmd.set_sstate) begin
                r_res_sstate <= i_cmd.sstate_from_rd ? rd_state : i_cmd.sstate;
            end
            if (i_cmd.alloc) begin
                r_res_rpid <= PID_W'(r_pick);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= r_res_status;
            r_out_rpid    <= r_res_rpid;
            r_out_sstate  <= r_res_sstate;
            r_out_running <= PID_W'(r_current);
        end
    end

    assign o_res_valid       = r_out_valid;
    assign o_res_status      = r_out_status;
    assign o_res_result_pid  = r_out_rpid;
    assign o_res_slot_state  = r_out_sstate;
    assign o_res_running_pid = r_out_running;

    always_comb begin
        o_stat.kind        = r_kind;
        o_stat.slot_valid  = (32'(r_slot) < SLOTS);
        o_stat.slot_zero   = (r_slot == '0);
        o_stat.slot_is_cur = (slot_idx == r_current);
        o_stat.enable      = r_enable;
        o_stat.rd_state    = rd_state;
        o_stat.scan_done   = scan_done;
        o_stat.found       = r_found;
        o_stat.pick_is_cur = (r_pick == r_current);
        o_stat.out_free    = !r_out_valid || i_res_ready;
    end

endmodule

[design/psrr_ctrl.sv]
module psrr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  psrr_pkg::t_dp_stat i_stat,
    output psrr_pkg::t_dp_cmd  o_cmd
);
    import psrr_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    t_kind       kind;
    logic        not_term;

    assign kind     = t_kind'(i_stat.kind);
    assign not_term = (kind != K_TERMINATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (kind)
                    K_CREATE: n_state = S_SCAN;
                    K_START, K_TERMINATE, K_FREE, K_READ: begin
                        n_state = i_stat.slot_valid ? S_TCHK : S_DONE;
                    end
                    K_YIELD:    n_state = i_stat.enable ? S_YCHK : S_CURRPT;
                    K_SCHEDULE: n_state = i_stat.enable ? S_SCAN : S_CURRPT;
                    default:    n_state = S_DONE;
                endcase
            end
            S_TCHK: begin
                n_state = S_DONE;
                if (kind == K_TERMINATE && !i_stat.slot_zero
                    && i_stat.rd_state != SS_EMPTY && i_stat.rd_state != SS_TERMINATED
                    && i_stat.slot_is_cur && i_stat.enable) begin
                    n_state = S_SCAN;
                end
            end
            S_YCHK: begin
                n_state = (i_stat.rd_state == SS_RUNNING) ? S_SCAN : S_DONE;
            end
            S_CURRPT: n_state = S_DONE;
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_POST;
            end
            S_POST: begin
                if (kind == K_CREATE) begin
                    n_state = S_DONE;
                end else begin
                    n_state = i_stat.pick_is_cur ? S_FIXCUR : S_SWOLD;
                end
            end
            S_FIXCUR: n_state = S_DONE;
            S_SWOLD:  n_state = S_SWNEW;
            S_SWNEW:  n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_CURRENT;
        o_cmd_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                o_cmd.load  = i_cmd_valid;
            end
            S_DECODE: begin
                case (kind)
                    K_CREATE: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_base  = BASE_LAST;
                        o_cmd.scan_want  = SS_EMPTY;
                    end
                    K_START, K_TERMINATE, K_FREE, K_READ: begin
                        o_cmd.rd_sel = RD_TARGET;
                        if (!i_stat.slot_valid) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = RS_BAD_SLOT;
                        end
                    end
                    K_YIELD: begin
                        if (!i_stat.enable) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = RS_DISABLED;
                        end
                    end
                    K_SCHEDULE: begin
                        if (!i_stat.enable) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = RS_DISABLED;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_base  = BASE_CURRENT;
                            o_cmd.scan_want  = SS_READY;
                        end
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = RS_BAD_STATE;
                    end
                endcase
            end
            S_TCHK: begin
                o_cmd.set_sstate = 1'b1;
                case (kind)
                    K_READ: begin
                        o_cmd.sstate_from_rd = 1'b1;
                    end
                    K_START: begin
                        if (i_stat.rd_state == SS_EMPTY) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = RS_BAD_SLOT;
                            o_cmd.sstate     = SS_EMPTY;
                        end else if (i_stat.rd_state != SS_CREATED) begin
                            o_cmd.set_status     = 1'b1;
                            o_cmd.status         = RS_BAD_STATE;
                            o_cmd.sstate_from_rd = 1'b1;
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_sel   = WR_TARGET;
                            o_cmd.wr_state = SS_READY;
                            o_cmd.sstate   = SS_READY;
                        end
                    end
                    K_TERMINATE: begin
                        if (i_stat.slot_zero || i_stat.rd_state == SS_EMPTY) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = RS_BAD_SLOT;
                            o_cmd.sstate     = SS_EMPTY;
                        end else if (i_stat.rd_state == SS_TERMINATED) begin
                            o_cmd.set_status     = 1'b1;
                            o_cmd.status         = RS_BAD_STATE;
                            o_cmd.sstate_from_rd = 1'b1;
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_sel   = WR_TARGET;
                            o_cmd.wr_state = SS_TERMINATED;
                            o_cmd.sstate   = SS_TERMINATED;
                            if (i_stat.slot_is_cur && i_stat.enable) begin
                                o_cmd.scan_start = 1'b1;
                                o_cmd.scan_base  = BASE_CURRENT;
                                o_cmd.scan_want  = SS_READY;
                            end
                        end
                    end
                    K_FREE: begin
                        if (i_stat.slot_zero || i_stat.rd_state == SS_EMPTY) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = RS_BAD_SLOT;
                            o_cmd.sstate     = SS_EMPTY;
                        end else if (i_stat.slot_is_cur) begin
                            o_cmd.set_status     = 1'b1;
                            o_cmd.status         = RS_BAD_STATE;
                            o_cmd.sstate_from_rd = 1'b1;
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_sel   = WR_TARGET;
                            o_cmd.wr_state = SS_EMPTY;
                            o_cmd.sstate   = SS_EMPTY;
                        end
                    end
                    default: begin
                        o_cmd.set_sstate = 1'b0;
                    end
                endcase
            end
            S_YCHK: begin
                if (i_stat.rd_state == SS_RUNNING) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_sel     = WR_CURRENT;
                    o_cmd.wr_state   = SS_READY;
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_base  = BASE_CURRENT;
                    o_cmd.scan_want  = SS_READY;
                end else begin
                    o_cmd.set_sstate     = 1'b1;
                    o_cmd.sstate_from_rd = 1'b1;
                end
            end
            S_CURRPT: begin
                o_cmd.set_sstate     = 1'b1;
                o_cmd.sstate_from_rd = 1'b1;
            end
            S_SCAN: begin
                o_cmd.rd_sel   = RD_SCAN;
                o_cmd.scan_run = 1'b1;
            end
            S_POST: begin
                if (kind == K_CREATE) begin
                    if (i_stat.found) begin
                        o_cmd.wr_en      = 1'b1;
                        o_cmd.wr_sel     = WR_PICK;
                        o_cmd.wr_state   = SS_CREATED;
                        o_cmd.alloc      = 1'b1;
                        o_cmd.set_sstate = 1'b1;
                        o_cmd.sstate     = SS_CREATED;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = RS_FULL;
                    end
                end
            end
            S_FIXCUR: begin
                o_cmd.set_sstate = not_term;
                if (i_stat.rd_state == SS_READY) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_sel   = WR_CURRENT;
                    o_cmd.wr_state = SS_RUNNING;
                    o_cmd.sstate   = SS_RUNNING;
                end else begin
                    o_cmd.sstate_from_rd = 1'b1;
                end
            end
            S_SWOLD: begin
                o_cmd.do_switch = 1'b1;
                if (i_stat.rd_state == SS_RUNNING) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_sel   = WR_CURRENT;
                    o_cmd.wr_state = SS_READY;
                end
            end
            S_SWNEW: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_sel     = WR_CURRENT;
                o_cmd.wr_state   = SS_RUNNING;
                o_cmd.set_sstate = not_term;
                o_cmd.sstate     = SS_RUNNING;
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

[design/psrr_checker.sv]
module psrr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [psrr_pkg::STATUS_W-1:0] i_res_status,
    input logic [psrr_pkg::PID_W-1:0]    i_res_result_pid,
    input logic [psrr_pkg::STATE_W-1:0]  i_res_slot_state,
    input logic [psrr_pkg::PID_W-1:0]    i_res_running_pid
);
    import psrr_pkg::*;

    // Hold a stalled result word
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status)
            && $stable(i_res_result_pid) && $stable(i_res_slot_state)
            && $stable(i_res_running_pid))
        else $error("result word changed while stalled");

    // One command at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command accepted while previous one in progress");

    // A fresh result only appears while the block is busy
    a_res_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> !$past(i_cmd_ready))
        else $error("result appeared without a command in progress");

    // A nonzero allocated slot only comes from a successful create
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_result_pid != '0 |->
            i_res_status == RS_OK && i_res_slot_state == SS_CREATED)
        else $error("allocated slot reported with wrong status or state");

endmodule

bind process_slot_round_robin_scheduler psrr_checker u_psrr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_status      (o_res.status),
    .i_res_result_pid  (o_res.result_pid),
    .i_res_slot_state  (o_res.slot_state_out),
    .i_res_running_pid (o_res.running_pid)
);

[dv/psrr_slot_checker.sv]
module psrr_slot_checker
    import psrr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    psrr_cmd_if   i_cmd,
    psrr_res_if   i_res,
    psrr_cfg_if   i_cfg,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status          status;
        logic [PID_W-1:0] pid;
        t_slot_state      state;
        logic [PID_W-1:0] running;
    } t_result_word;

    t_slot_state      slot_tbl [SLOTS];
    logic [IDX_W-1:0] cur_slot;
    logic [IDX_W-1:0] last_alloc;
    logic [31:0]      switch_count;
    logic             sched_en;
    t_result_word     expected_words [$];
    int               words_seen;

    task automatic report(string msg);
        $display("ERROR: %0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            slot_tbl[i] = SS_EMPTY;
        end
        slot_tbl[0]  = SS_RUNNING;
        cur_slot     = '0;
        last_alloc   = '0;
        switch_count = '0;
        sched_en     = 1'b0;
    endfunction

    // First ready slot after the current one, else idle
    function automatic void run_round_robin();
        int pick;
        int p;
        bit found;
        pick  = 0;
        found = 1'b0;
        for (int i = 1; i <= SLOTS; i++) begin
            p = (int'(cur_slot) + i) % SLOTS;
            if (!found && p != 0 && slot_tbl[p] == SS_READY) begin
                pick  = p;
                found = 1'b1;
            end
        end
        if (pick == int'(cur_slot)) begin
            if (slot_tbl[pick] == SS_READY) slot_tbl[pick] = SS_RUNNING;
        end else begin
            switch_count++;
            if (slot_tbl[cur_slot] == SS_RUNNING) slot_tbl[cur_slot] = SS_READY;
            slot_tbl[pick] = SS_RUNNING;
            cur_slot       = IDX_W'(pick);
        end
    endfunction

    function automatic t_result_word predict_word(logic [KIND_W-1:0] kind,
                                                  logic [PID_W-1:0]  pid);
        t_result_word w;
        bit           in_table;
        bit           found;
        t_slot_state  tgt;
        int           slot_n;
        int           p;
        w.status = RS_OK;
        w.pid    = '0;
        w.state  = SS_EMPTY;
        slot_n   = int'(pid);
        in_table = slot_n < SLOTS;
        tgt      = in_table ? slot_tbl[slot_n] : SS_EMPTY;
        found    = 1'b0;
        case (kind)
            K_CREATE: begin
                w.status = RS_FULL;
                for (int i = 1; i <= SLOTS; i++) begin
                    p = (int'(last_alloc) + i) % SLOTS;
                    if (!found && p != 0 && slot_tbl[p] == SS_EMPTY) begin
                        slot_tbl[p] = SS_CREATED;
                        last_alloc  = IDX_W'(p);
                        w.pid       = PID_W'(p);
                        w.state     = SS_CREATED;
                        w.status    = RS_OK;
                        found       = 1'b1;
                    end
                end
            end
            K_START: begin
                if (!in_table || tgt == SS_EMPTY) begin
                    w.status = RS_BAD_SLOT;
                end else if (tgt != SS_CREATED) begin
                    w.status = RS_BAD_STATE;
                    w.state  = tgt;
                end else begin
                    slot_tbl[slot_n] = SS_READY;
                    w.state          = SS_READY;
                end
            end
            K_TERMINATE: begin
                if (!in_table || slot_n == 0 || tgt == SS_EMPTY) begin
                    w.status = RS_BAD_SLOT;
                end else if (tgt == SS_TERMINATED) begin
                    w.status = RS_BAD_STATE;
                    w.state  = tgt;
                end else begin
                    slot_tbl[slot_n] = SS_TERMINATED;
                    if (slot_n == int'(cur_slot) && sched_en) run_round_robin();
                    w.state = slot_tbl[slot_n];
                end
            end
            K_FREE: begin
                if (!in_table || slot_n == 0 || tgt == SS_EMPTY) begin
                    w.status = RS_BAD_SLOT;
                end else if (slot_n == int'(cur_slot)) begin
                    w.status = RS_BAD_STATE;
                    w.state  = tgt;
                end else begin
                    slot_tbl[slot_n] = SS_EMPTY;
                end
            end
            K_YIELD: begin
                if (!sched_en) begin
                    w.status = RS_DISABLED;
                end else if (slot_tbl[cur_slot] == SS_RUNNING) begin
                    slot_tbl[cur_slot] = SS_READY;
                    run_round_robin();
                end
                w.state = slot_tbl[cur_slot];
            end
            K_SCHEDULE: begin
                if (!sched_en) w.status = RS_DISABLED;
                else run_round_robin();
                w.state = slot_tbl[cur_slot];
            end
            K_READ: begin
                if (!in_table) w.status = RS_BAD_SLOT;
                else w.state = tgt;
            end
            default: begin
                w.status = RS_BAD_STATE;
            end
        endcase
        w.running = PID_W'(cur_slot);
        return w;
    endfunction

    task automatic compare_field(string name, int got, int want);
        if (got != want) begin
            report($sformatf("result word %0d: %s is %0d, expected %0d",
                             words_seen, name, got, want));
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        words_seen   = 0;
        clear_table();
    end

    // Retire results before taking new commands: no result can stem from a
    // command accepted at the same edge.
    always @(posedge i_clk) begin
        t_result_word want;
        if (!i_rst_n) begin
            clear_table();
            expected_words.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) sched_en = i_cfg.scheduler_enable;
            if (i_res.valid && i_res.ready) begin
                if (expected_words.size() == 0) begin
                    report($sformatf("result word %0d arrived with nothing pending",
                                     words_seen));
                end else begin
                    want = expected_words.pop_front();
                    compare_field("status", int'(i_res.status), int'(want.status));
                    compare_field("result_pid", int'(i_res.result_pid), int'(want.pid));
                    compare_field("slot_state_out", int'(i_res.slot_state_out),
                                  int'(want.state));
                    compare_field("running_pid", int'(i_res.running_pid),
                                  int'(want.running));
                end
                words_seen++;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_words.push_back(predict_word(i_cmd.kind, i_cmd.slot_pid));
            end
        end
        o_pending = expected_words.size();
    end

endmodule

[dv/process_slot_round_robin_scheduler_tb.sv]
module process_slot_round_robin_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psrr_pkg::*;

    // Kind code outside the defined set
    localparam logic [KIND_W-1:0] K_UNDEFINED = 3'd7;
    // Wait after the block drains, with margin over the longest command
    localparam int DRAIN_CYCLES = SLOTS + 16;
    localparam int PHASE_WORDS  = 230;
    localparam int HOLD_CYCLES  = 400;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   words_sent;
    int   results_taken;
    bit   no_idle;

    psrr_cmd_if cmd_bus ();
    psrr_res_if res_bus ();
    psrr_cfg_if cfg_bus ();

    process_slot_round_robin_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    psrr_slot_checker u_slot_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_res        (res_bus),
        .i_cfg        (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Offer one command word; the task starts and ends on a falling edge.
    // Keep valid high across back-to-back words rather than toggling it.
    task automatic send_word(logic [KIND_W-1:0] kind, logic [PID_W-1:0] pid);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.kind     <= kind;
        cmd_bus.slot_pid <= pid;
        do @(posedge i_clk); while (!cmd_bus.ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drain the block, then write the enable through its own channel
    task automatic write_enable(logic value);
        cmd_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_bus.valid            <= 1'b1;
        cfg_bus.scheduler_enable <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly lifecycle traffic on random slots, with an occasional run of
    // creates to fill the table and a sprinkling of undefined kinds.
    task automatic send_random_item();
        int roll;
        logic [PID_W-1:0] pid;
        roll = $urandom_range(0, 99);
        pid  = PID_W'($urandom_range(0, SLOTS - 1));
        if (roll < 4) begin
            repeat (SLOTS) send_word(K_CREATE, PID_W'($urandom_range(0, SLOTS - 1)));
        end else if (roll < 28) begin
            send_word(K_CREATE, pid);
        end else if (roll < 52) begin
            send_word(K_START, pid);
        end else if (roll < 62) begin
            send_word(K_SCHEDULE, pid);
        end else if (roll < 70) begin
            send_word(K_YIELD, pid);
        end else if (roll < 82) begin
            send_word(K_TERMINATE, pid);
        end else if (roll < 93) begin
            send_word(K_FREE, pid);
        end else if (roll < 98) begin
            send_word(K_READ, pid);
        end else begin
            send_word(K_UNDEFINED, pid);
        end
    endtask

    // Result side: random stall before each word, plus two long hold-offs
    // while the sender keeps offering, so the output register fills and
    // the block backs up onto its command input.
    initial begin
        int stall;
        results_taken = 0;
        res_bus.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (results_taken == 150 || results_taken == 900) stall = HOLD_CYCLES;
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
            results_taken++;
            @(negedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        logic phase_enables [6];
        int   phase_start;
        phase_enables = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        words_sent               = 0;
        no_idle                  = 1'b0;
        i_rst_n                  = 1'b0;
        cmd_bus.valid            = 1'b0;
        cmd_bus.kind             = K_CREATE;
        cmd_bus.slot_pid         = '0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.scheduler_enable = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: scheduler disabled first
        write_enable(1'b0);
        send_word(K_YIELD, 4'd0);        // disabled
        send_word(K_SCHEDULE, 4'd15);    // disabled
        send_word(K_READ, 4'd0);         // idle slot reads running
        send_word(K_READ, 4'd15);        // empty slot reads ok
        send_word(K_CREATE, 4'd0);       // allocates slot 1
        send_word(K_START, 4'd0);        // idle slot is never created
        send_word(K_START, 4'd5);        // empty target
        send_word(K_TERMINATE, 4'd0);    // idle slot
        send_word(K_FREE, 4'd0);         // idle slot
        send_word(K_UNDEFINED, 4'd15);   // unknown kind
        send_word(K_START, 4'd1);
        send_word(K_START, 4'd1);        // no longer created

        write_enable(1'b1);
        send_word(K_SCHEDULE, 4'd0);     // switch to slot 1
        send_word(K_YIELD, 4'd0);        // only itself ready: pick unchanged
        send_word(K_FREE, 4'd1);         // free of the running slot
        send_word(K_CREATE, 4'd15);      // slot 2
        send_word(K_START, 4'd2);
        send_word(K_TERMINATE, 4'd1);    // running slot: reschedule to 2
        send_word(K_TERMINATE, 4'd1);    // already terminated
        send_word(K_FREE, 4'd1);

        write_enable(1'b0);
        send_word(K_TERMINATE, 4'd2);    // running slot, no reschedule

        write_enable(1'b1);
        send_word(K_YIELD, 4'd0);        // current slot not running
        send_word(K_SCHEDULE, 4'd0);     // nothing ready: fall back to idle
        send_word(K_FREE, 4'd2);
        send_word(K_CREATE, 4'd0);       // search resumes after slot 2

        // Random phases, each with its own enable setting; no-idle stretches per chunk
        foreach (phase_enables[ph]) begin
            write_enable(phase_enables[ph]);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                if ((words_sent % 64) == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_random_item();
            end
            no_idle = 1'b0;
        end

        cmd_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
design/psrr_pkg.sv
design/psrr_ifs.sv
design/psrr_dp.sv
design/psrr_ctrl.sv
design/process_slot_round_robin_scheduler.sv
design/psrr_checker.sv
dv/psrr_slot_checker.sv
dv/process_slot_round_robin_scheduler_tb.sv
